FILE: src/lfu_cache_replacement_defines.svh
// assertion macros used by the lfu checker
`ifndef LFU_CACHE_REPLACEMENT_DEFINES_SVH
`define LFU_CACHE_REPLACEMENT_DEFINES_SVH

// clocked assertion with explicit clock and active-low reset
`define LFU_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lfu assertion failed");

// clocked assertion on the block clock and reset
`define LFU_ASSERT(lbl, prop) \
  `LFU_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: src/lfu_pkg.sv
// shared constants, types and structs of the lfu cache
package lfu_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CFG_W   = 5;
  localparam int KEY_W   = 32;
  localparam int USE_W   = 31;
  localparam int STAMP_W = 48;
  localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);
  localparam logic [USE_W-1:0] USES_MAX  = '1;
  localparam logic [KEY_W-1:0] NOT_FOUND = '1;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  // one entry as read from the store
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   value;
    logic [USE_W-1:0]   uses;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // store write port: one entry update plus one invalidate
  typedef struct packed {
    logic               en;
    logic               kv_en;
    logic               set_valid;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   value;
    logic [USE_W-1:0]   uses;
    logic [STAMP_W-1:0] stamp;
    logic               inv_en;
    logic [IDX_W-1:0]   inv_idx;
  } store_wr_t;

  // outcome of one full scan
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [KEY_W-1:0] hit_value;
    logic [USE_W-1:0] hit_uses;
    logic             vic;
    logic [IDX_W-1:0] vic_idx;
    logic [KEY_W-1:0] vic_key;
    logic             free;
    logic [IDX_W-1:0] free_idx;
    logic [CNT_W-1:0] count;
  } scan_res_t;

endpackage

FILE: src/lfu_store.sv
// entry storage: valid bits, keys, values, use counts and touch stamps
module lfu_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lfu_pkg::IDX_W-1:0] rd_idx_i,
  output lfu_pkg::entry_t           rd_o,
  input  lfu_pkg::store_wr_t        wr_i
);

  logic                        valid_q [lfu_pkg::ENTRIES];
  logic [lfu_pkg::KEY_W-1:0]   key_q   [lfu_pkg::ENTRIES];
  logic [lfu_pkg::KEY_W-1:0]   value_q [lfu_pkg::ENTRIES];
  logic [lfu_pkg::USE_W-1:0]   uses_q  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::STAMP_W-1:0] stamp_q [lfu_pkg::ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      // invalidate first so a set on the same slot wins
      if (wr_i.inv_en) begin
        valid_q[wr_i.inv_idx] <= 1'b0;
      end
      if (wr_i.en && wr_i.set_valid) begin
        valid_q[wr_i.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      uses_q[wr_i.idx]  <= wr_i.uses;
      stamp_q[wr_i.idx] <= wr_i.stamp;
      if (wr_i.kv_en) begin
        key_q[wr_i.idx]   <= wr_i.key;
        value_q[wr_i.idx] <= wr_i.value;
      end
    end
  end

  assign rd_o.valid = valid_q[rd_idx_i];
  assign rd_o.key   = key_q[rd_idx_i];
  assign rd_o.value = value_q[rd_idx_i];
  assign rd_o.uses  = uses_q[rd_idx_i];
  assign rd_o.stamp = stamp_q[rd_idx_i];

endmodule

FILE: src/lfu_scan.sv
// shared compare unit: key match, victim search and free slot, one entry a cycle while step_i is high
module lfu_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      step_i,
  input  logic [lfu_pkg::IDX_W-1:0] idx_i,
  input  logic [lfu_pkg::KEY_W-1:0] key_i,
  input  lfu_pkg::entry_t           entry_i,
  output lfu_pkg::scan_res_t        res_o
);

  lfu_pkg::scan_res_t          res_q, res_d;
  logic [lfu_pkg::STAMP_W-1:0] best_stamp_q, best_stamp_d;
  logic [lfu_pkg::USE_W-1:0]   best_uses_q, best_uses_d;
  logic                        older;

  // lower count first, then older stamp, in one wide compare
  assign older = {entry_i.uses, entry_i.stamp} < {best_uses_q, best_stamp_q};

  always_comb begin
    res_d        = res_q;
    best_uses_d  = best_uses_q;
    best_stamp_d = best_stamp_q;
    if (clear_i) begin
      res_d = '0;
    end else if (step_i) begin
      if (entry_i.valid) begin
        res_d.count = res_q.count + 1'b1;
        if (entry_i.key == key_i && !res_q.hit) begin
          res_d.hit       = 1'b1;
          res_d.hit_idx   = idx_i;
          res_d.hit_value = entry_i.value;
          res_d.hit_uses  = entry_i.uses;
        end
        if (!res_q.vic || older) begin
          res_d.vic     = 1'b1;
          res_d.vic_idx = idx_i;
          res_d.vic_key = entry_i.key;
          best_uses_d   = entry_i.uses;
          best_stamp_d  = entry_i.stamp;
        end
      end else if (!res_q.free) begin
        res_d.free     = 1'b1;
        res_d.free_idx = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_uses_q  <= best_uses_d;
    best_stamp_q <= best_stamp_d;
  end

  assign res_o = res_q;

endmodule

FILE: src/lfu_cache_replacement.sv
// top level of the lfu key-value cache: sequencer, config register, result port
//
// usage
// - command channel: an item (mode_i, lookup_key_i, write_value_i) is taken at a
//   rising edge with start high and busy low; mode 0 is a get, mode 1 a put
// - busy stays high from the accept edge through the scan, one entry per cycle
//   through the shared compare unit, and then through the update state that
//   writes the chosen slot
// - the result shows for one cycle with done_o high, in the cycle after the
//   update; busy is already low then, so the next item may start in that cycle
// - items do not overlap: a new item is taken only after the last one has passed its update
// - the receiver cannot stall: each result is taken at the edge ending its cycle
// - config channel: cfg_data_i sets capacity_in_use at an edge with cfg_valid_i
//   and cfg_ready_o high; ready is low while an item is at work
// - reset: all slots invalid, touch counter zero, capacity 16, no result pending;
//   no clearing pass, the valid bits clear at once
module lfu_cache_replacement (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      mode_i,
  input  logic [lfu_pkg::KEY_W-1:0] lookup_key_i,
  input  logic [lfu_pkg::KEY_W-1:0] write_value_i,
  // result channel
  output logic                      done_o,
  output logic                      found_o,
  output logic [lfu_pkg::KEY_W-1:0] read_value_o,
  output logic                      evicted_o,
  output logic [lfu_pkg::KEY_W-1:0] evicted_key_o,
  // config channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lfu_pkg::CFG_W-1:0] cfg_data_i
);

  lfu_pkg::state_e               state_q, state_d;
  logic [lfu_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic                          mode_q;
  logic [lfu_pkg::KEY_W-1:0]     key_q, val_q;
  logic [lfu_pkg::CFG_W-1:0]     cap_q;
  logic [lfu_pkg::STAMP_W-1:0]   touch_q, touch_d;

  // result registers
  logic                          done_q, done_d;
  logic                          found_q, found_d;
  logic [lfu_pkg::KEY_W-1:0]     rd_q, rd_d;
  logic                          ev_q, ev_d;
  logic [lfu_pkg::KEY_W-1:0]     evk_q, evk_d;

  logic                          accept;
  logic                          scan_clear, scan_step;
  lfu_pkg::entry_t               entry;
  lfu_pkg::scan_res_t            res;
  lfu_pkg::store_wr_t            wr;

  logic [lfu_pkg::CMP_W-1:0]     cap_ext, cap_eff, cnt_ext;
  logic [lfu_pkg::USE_W-1:0]     uses_inc;
  logic                          do_evict, do_insert;
  logic [lfu_pkg::IDX_W-1:0]     ins_idx;

  assign accept      = start && !busy;
  assign busy        = (state_q != lfu_pkg::ST_IDLE);
  assign cfg_ready_o = !busy;

  lfu_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (idx_q),
    .rd_o     (entry),
    .wr_i     (wr)
  );

  lfu_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (scan_clear),
    .step_i   (scan_step),
    .idx_i    (idx_q),
    .key_i    (key_q),
    .entry_i  (entry),
    .res_o    (res)
  );

  // capacity above the entry count acts as the entry count
  assign cap_ext  = lfu_pkg::CMP_W'(cap_q);
  assign cap_eff  = (cap_ext > lfu_pkg::CMP_W'(lfu_pkg::ENTRIES)) ?
                    lfu_pkg::CMP_W'(lfu_pkg::ENTRIES) : cap_ext;
  assign cnt_ext  = lfu_pkg::CMP_W'(res.count);

  // saturating use count of the hit entry
  assign uses_inc = (res.hit_uses == lfu_pkg::USES_MAX) ?
                    res.hit_uses : res.hit_uses + 1'b1;

  // a store at its capacity gives up its victim; the new entry takes the lower of
  // the victim slot and the first free slot
  assign do_evict  = (cnt_ext >= cap_eff) && res.vic;
  assign do_insert = do_evict || res.free;
  assign ins_idx   = (do_evict && !(res.free && (res.free_idx < res.vic_idx))) ?
                     res.vic_idx : res.free_idx;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    touch_d    = touch_q;
    scan_clear = 1'b0;
    scan_step  = 1'b0;
    wr         = '0;
    done_d     = 1'b0;
    found_d    = found_q;
    rd_d       = rd_q;
    ev_d       = ev_q;
    evk_d      = evk_q;

    case (state_q)
      lfu_pkg::ST_IDLE: begin
        if (start) begin
          scan_clear = 1'b1;
          idx_d      = '0;
          state_d    = lfu_pkg::ST_SCAN;
        end
      end

      lfu_pkg::ST_SCAN: begin
        scan_step = 1'b1;
        if (idx_q == lfu_pkg::IDX_W'(lfu_pkg::ENTRIES - 1)) begin
          state_d = lfu_pkg::ST_UPDATE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      lfu_pkg::ST_UPDATE: begin
        state_d = lfu_pkg::ST_IDLE;
        done_d  = 1'b1;
        found_d = res.hit;
        rd_d    = '0;
        ev_d    = 1'b0;
        evk_d   = '0;
        if (mode_q == lfu_pkg::MODE_GET) begin
          if (res.hit) begin
            rd_d     = res.hit_value;
            wr.en    = 1'b1;
            wr.idx   = res.hit_idx;
            wr.uses  = uses_inc;
            wr.stamp = touch_q;
            touch_d  = touch_q + 1'b1;
          end else begin
            rd_d = lfu_pkg::NOT_FOUND;
          end
        end else if (cap_q != '0) begin
          if (res.hit) begin
            // overwrite in place, counts as a use
            wr.en    = 1'b1;
            wr.kv_en = 1'b1;
            wr.idx   = res.hit_idx;
            wr.key   = key_q;
            wr.value = val_q;
            wr.uses  = uses_inc;
            wr.stamp = touch_q;
            touch_d  = touch_q + 1'b1;
          end else begin
            if (do_evict) begin
              ev_d       = 1'b1;
              evk_d      = res.vic_key;
              wr.inv_en  = 1'b1;
              wr.inv_idx = res.vic_idx;
            end
            if (do_insert) begin
              wr.en        = 1'b1;
              wr.kv_en     = 1'b1;
              wr.set_valid = 1'b1;
              wr.idx       = ins_idx;
              wr.key       = key_q;
              wr.value     = val_q;
              wr.uses      = lfu_pkg::USE_W'(1);
              wr.stamp     = touch_q;
              touch_d      = touch_q + 1'b1;
            end
          end
        end
      end

      default: begin
        state_d = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfu_pkg::ST_IDLE;
      idx_q   <= '0;
      touch_q <= '0;
      cap_q   <= lfu_pkg::CAP_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      touch_q <= touch_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // item payload and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      key_q  <= lookup_key_i;
      val_q  <= write_value_i;
    end
    found_q <= found_d;
    rd_q    <= rd_d;
    ev_q    <= ev_d;
    evk_q   <= evk_d;
  end

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign read_value_o  = rd_q;
  assign evicted_o     = ev_q;
  assign evicted_key_o = evk_q;

endmodule

FILE: src/lfu_checker.sv
// port-level checker of the lfu cache and its bind
`include "lfu_cache_replacement_defines.svh"

module lfu_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input logic                      found_o,
  input logic                      evicted_o,
  input logic [lfu_pkg::KEY_W-1:0] evicted_key_o
);

  // a result never shows while an item is at work
  `LFU_ASSERT(a_done_idle, done_o |-> !busy)
  // an accepted item makes the block busy
  `LFU_ASSERT(a_accept_busy, start && !busy |=> busy)
  // the strobe lasts one cycle
  `LFU_ASSERT(a_done_pulse, done_o |=> !done_o)
  // eviction only when the key is not found, and the key reads zero otherwise
  `LFU_ASSERT(a_evict_miss, done_o && evicted_o |-> !found_o)
  `LFU_ASSERT(a_evict_key_zero, done_o && !evicted_o |-> evicted_key_o == '0)

endmodule

bind lfu_cache_replacement lfu_checker u_lfu_checker (.*);
